@@ hw/rtl/htg_pkg.sv @@
// ----------------------------------------------------------------------------
// htg_pkg
// Shared types and constants of the page-number hash table.
// ----------------------------------------------------------------------------
package htg_pkg;

   localparam int KEY_W         = 13;
   localparam logic [KEY_W-1:0] KEY_LIMIT = 13'h10FF;
   localparam int CSR_W         = 9;
   localparam logic [CSR_W-1:0] CSR_RESET = 9'd256;
   localparam int SLOT_OUT_W    = 8;
   localparam int COUNT_OUT_W   = 9;
   localparam int SLOTS_DEFAULT = 256;

   // The remainder unit retires two dividend bits per cycle.
   localparam int DIV_DW    = KEY_W + (KEY_W % 2);
   localparam int DIV_STEPS = DIV_DW / 2;
   localparam int DIV_CW    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   typedef enum logic [1:0] {
      STATUS_HIT      = 2'd0,
      STATUS_INSERTED = 2'd1,
      STATUS_RANGE    = 2'd2,
      STATUS_FULL     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_PROBE,
      ST_FINISH
   } state_type;

endpackage

@@ hw/rtl/htg_ifs.sv @@
// ----------------------------------------------------------------------------
// htg_ifs
// Valid/ready channels for the request and response beats.
// ----------------------------------------------------------------------------
interface htg_req_if
   import htg_pkg::*;
   ;
   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] page_key;

   modport source (output valid, output page_key, input ready);
   modport sink (input valid, input page_key, output ready);
endinterface

interface htg_rsp_if
   import htg_pkg::*;
   ;
   logic                   valid;
   logic                   ready;
   status_type             status;
   logic [SLOT_OUT_W-1:0]  slot_index;
   logic [COUNT_OUT_W-1:0] entry_count;

   modport source (output valid, output status, output slot_index, output entry_count,
                   input ready);
   modport sink (input valid, input status, input slot_index, input entry_count,
                 output ready);
endinterface

@@ hw/rtl/hash_table_get_or_insert.sv @@
// ----------------------------------------------------------------------------
// hash_table_get_or_insert
// Open-addressed page-number table with linear probing: find or insert.
// ----------------------------------------------------------------------------
// Channel   Direction  Beat contents
// req_chan  in         page_key
// rsp_chan  out        status, slot_index, entry_count
// csr       in         slots_in_use (write only)
//
// A request is accepted, the remainder unit forms its home slot, the home
// slot is read, the slots are probed in turn through the table RAM read
// port, and the response register is loaded. Out-of-range keys and zero
// slots in use skip the remainder and probe phases. After reset the table
// RAM is cleared one slot per cycle, every slot, before the first request
// is taken. A stalled response holds the next request in its final state
// until the output register is free.
// ----------------------------------------------------------------------------
module hash_table_get_or_insert
   import htg_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_wdata,
   htg_req_if.sink          req_chan,
   htg_rsp_if.source        rsp_chan
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int NW = $clog2(SLOTS + 1);
   localparam int CW = (NW > CSR_W) ? NW : CSR_W;
   localparam int SW = (IW > SLOT_OUT_W) ? IW : SLOT_OUT_W;
   localparam int OW = (NW > COUNT_OUT_W) ? NW : COUNT_OUT_W;
   localparam int EW = KEY_W + 1;

   state_type              state_ff, state_in;
   logic [CSR_W-1:0]       csr_ff;
   logic [IW-1:0]          clr_ff, clr_in;
   logic [NW-1:0]          occ_ff, occ_in;
   logic [NW-1:0]          n_ff, n_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [IW-1:0]          pos_ff, pos_in;
   logic [NW-1:0]          step_ff, step_in;
   status_type             res_status_ff, res_status_in;
   logic [IW-1:0]          res_slot_ff, res_slot_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [SLOT_OUT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [CW-1:0] n_wide;
   logic [NW-1:0] n_eff;
   logic [NW-1:0] pos_inc;
   logic [IW-1:0] pos_next;
   logic [SW-1:0] slot_wide;
   logic [OW-1:0] count_wide;
   logic          out_free;
   logic          req_accept;

   logic          ram_we;
   logic [IW-1:0] ram_waddr;
   logic [EW-1:0] ram_wdata;
   logic [IW-1:0] ram_raddr;
   logic [EW-1:0] ram_rdata;
   logic          ent_valid;
   logic [KEY_W-1:0] ent_key;

   logic          rem_start;
   logic          rem_done;
   logic [NW-1:0] rem_value;

   htg_ram #(
      .WIDTH (EW),
      .DEPTH (SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   htg_rem #(
      .NW (NW)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (key_in),
      .divisor   (n_in),
      .done      (rem_done),
      .remainder (rem_value)
   );

   assign n_wide    = (CW'(csr_ff) > CW'(SLOTS)) ? CW'(SLOTS) : CW'(csr_ff);
   assign n_eff     = n_wide[NW-1:0];
   assign pos_inc   = NW'(pos_ff) + 1'b1;
   assign pos_next  = (pos_inc == n_ff) ? '0 : pos_inc[IW-1:0];
   assign ent_valid = ram_rdata[EW-1];
   assign ent_key   = ram_rdata[KEY_W-1:0];
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept = req_chan.valid && req_chan.ready;
   assign slot_wide  = SW'(res_slot_ff);
   assign count_wide = OW'(occ_ff);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      occ_in        = occ_ff;
      n_in          = n_ff;
      key_in        = key_ff;
      pos_in        = pos_ff;
      step_in       = step_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_count_in  = rsp_count_ff;
      ram_we        = 1'b0;
      ram_waddr     = pos_ff;
      ram_wdata     = {1'b1, key_ff};
      ram_raddr     = pos_ff;
      rem_start     = 1'b0;
      req_chan.ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == IW'(SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               key_in      = req_chan.page_key;
               n_in        = n_eff;
               res_slot_in = '0;
               if (req_chan.page_key > KEY_LIMIT) begin
                  res_status_in = STATUS_RANGE;
                  state_in      = ST_FINISH;
               end else if (n_eff == '0) begin
                  res_status_in = STATUS_FULL;
                  state_in      = ST_FINISH;
               end else begin
                  rem_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (rem_done) begin
               pos_in    = rem_value[IW-1:0];
               step_in   = '0;
               ram_raddr = rem_value[IW-1:0];
               state_in  = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (!ent_valid) begin
               ram_we        = 1'b1;
               occ_in        = occ_ff + 1'b1;
               res_status_in = STATUS_INSERTED;
               res_slot_in   = pos_ff;
               state_in      = ST_FINISH;
            end else if (ent_key == key_ff) begin
               res_status_in = STATUS_HIT;
               res_slot_in   = pos_ff;
               state_in      = ST_FINISH;
            end else if (step_ff == n_ff - 1'b1) begin
               res_status_in = STATUS_FULL;
               res_slot_in   = '0;
               state_in      = ST_FINISH;
            end else begin
               pos_in    = pos_next;
               step_in   = step_ff + 1'b1;
               ram_raddr = pos_next;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = slot_wide[SLOT_OUT_W-1:0];
               rsp_count_in  = count_wide[COUNT_OUT_W-1:0];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         csr_ff       <= CSR_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            csr_ff <= csr_wdata;
         end
      end
      n_ff          <= n_in;
      key_ff        <= key_in;
      pos_ff        <= pos_in;
      step_ff       <= step_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.slot_index  = rsp_slot_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

   // An insertion raises the occupancy by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE && ram_we) |=> (occ_ff == NW'($past(occ_ff) + 1'b1)))
      else $error("occupancy did not follow an insertion");

   // The probe stays inside the slots in use and within one lap.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> (NW'(pos_ff) < n_ff && step_ff < n_ff))
      else $error("probe left the slots in use");

   // The remainder unit finishes only while a request waits for its home slot.
   assert property (@(posedge clock) disable iff (reset)
      rem_done |-> (state_ff == ST_DIV))
      else $error("home slot produced outside the division phase");

   // No request beat is taken while a result is still being formed.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != ST_IDLE))
      else $error("request accepted without leaving idle");

endmodule

@@ hw/rtl/htg_ram.sv @@
// ----------------------------------------------------------------------------
// htg_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module htg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/htg_rem.sv @@
// ----------------------------------------------------------------------------
// htg_rem
// Iterative remainder unit: key modulo divisor, two bits per cycle.
// ----------------------------------------------------------------------------
module htg_rem
   import htg_pkg::*;
#(
   parameter int NW = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [KEY_W-1:0] dividend,
   input  logic [NW-1:0]    divisor,
   output logic             done,
   output logic [NW-1:0]    remainder
);

   logic [DIV_DW-1:0] sh_ff, sh_in;
   logic [NW-1:0]     rem_ff, rem_in;
   logic [NW-1:0]     div_ff, div_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [NW-1:0]     stage_rem;
   logic [NW:0]       trial;

   always_comb begin
      stage_rem = rem_ff;
      trial     = '0;
      for (int i = 0; i < 2; i++) begin
         trial = {stage_rem, sh_ff[DIV_DW-1-i]};
         if (trial >= {1'b0, div_ff}) begin
            trial = trial - {1'b0, div_ff};
         end
         stage_rem = trial[NW-1:0];
      end
   end

   always_comb begin
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         sh_in   = DIV_DW'(dividend);
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         sh_in  = {sh_ff[DIV_DW-3:0], 2'b00};
         rem_in = stage_rem;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CW'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
